// ----- rtl/core/cfrx_pkg.sv -----
// Shared types and constants for the checked frame receiver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package cfrx_pkg;

   localparam logic [7:0] SYNC_FIRST    = 8'hAA;
   localparam logic [7:0] SYNC_SECOND   = 8'hFF;
   localparam logic [7:0] PAYLOAD_LIMIT = 8'd50;

   localparam logic [7:0]  HEARTBEAT_CMD_RESET = 8'hF5;
   localparam logic [15:0] OFFLINE_LIMIT_RESET = 16'd2000;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEARTBEAT_CMD = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFLINE_LIMIT = 8'd1;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // parser phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_SYNC1   = 3'd1;
   localparam logic [2:0] PH_SYNC2   = 3'd2;
   localparam logic [2:0] PH_CMD     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_SUMCHK  = 3'd5;
   localparam logic [2:0] PH_ADDCHK  = 3'd6;

   // classified request beat, as held in the front queue
   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
      logic [7:0] tick_ms;
      logic       is_sync_first;
      logic       is_sync_second;
      logic       len_ok;
   } req_item_type;

   typedef struct packed {
      logic       frame_valid;
      logic [7:0] frame_command;
      logic       heartbeat_seen;
      logic       link_offline;
   } rsp_item_type;

   // front-to-back handshake
   typedef struct packed {
      logic         avail;
      req_item_type item;
   } front_out_type;

endpackage

// ----- rtl/core/checked_frame_receiver_with_link_timeout_unit.sv -----
// Checked frame receiver with link timeout: top level.
// A request beat is registered in the front queue, then in the result queue, before its result beat can be popped.
// Throughput: one beat per cycle; the back end retires one queued beat a cycle,
// gated only by space in the two-entry result queue.
// Reset (synchronous): empties both queues, idles the parser, clears the timer
// and offline flag, and loads the config registers with their defaults.
`timescale 1ns / 1ps
module checked_frame_receiver_with_link_timeout_unit import cfrx_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic                   req_opcode,
   input  logic [7:0]             req_rx_byte,
   input  logic [7:0]             req_tick_ms,
   output logic                   empty,
   input  logic                   pop,
   output logic                   rsp_frame_valid,
   output logic [7:0]             rsp_frame_command,
   output logic                   rsp_heartbeat_seen,
   output logic                   rsp_link_offline,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   front_out_type front_out;
   logic          take;
   logic          rsp_full;
   logic          rsp_push;
   rsp_item_type  rsp_item;
   rsp_item_type  head;

   cfrx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_opcode  (req_opcode),
      .req_rx_byte (req_rx_byte),
      .req_tick_ms (req_tick_ms),
      .front_out   (front_out),
      .take        (take)
   );

   cfrx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .front_out (front_out),
      .take      (take),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item)
   );

   cfrx_rsp_q u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .enq      (rsp_push),
      .enq_item (rsp_item),
      .q_full   (rsp_full),
      .pop      (pop),
      .empty    (empty),
      .head     (head)
   );

   assign rsp_frame_valid    = head.frame_valid;
   assign rsp_frame_command  = head.frame_command;
   assign rsp_heartbeat_seen = head.heartbeat_seen;
   assign rsp_link_offline   = head.link_offline;

endmodule

// ----- rtl/core/cfrx_front.sv -----
// Front end: accepts request beats, classifies each byte and queues it.
// Depends on cfrx_pkg.
`timescale 1ns / 1ps
module cfrx_front import cfrx_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   output logic          full,
   input  logic          req_opcode,
   input  logic [7:0]    req_rx_byte,
   input  logic [7:0]    req_tick_ms,
   output front_out_type front_out,
   input  logic          take
);

   req_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   req_item_type new_item;
   logic         push_ok, pop_ok;

   always_comb begin
      new_item.opcode         = req_opcode;
      new_item.rx_byte        = req_rx_byte;
      new_item.tick_ms        = req_tick_ms;
      new_item.is_sync_first  = (req_rx_byte == SYNC_FIRST);
      new_item.is_sync_second = (req_rx_byte == SYNC_SECOND);
      new_item.len_ok         = (req_rx_byte < PAYLOAD_LIMIT);
   end

   assign full            = (count_ff == 2'd2);
   assign push_ok         = push && !full;
   assign pop_ok          = take && (count_ff != 2'd0);
   assign front_out.avail = (count_ff != 2'd0);
   assign front_out.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ pop_ok;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- rtl/core/cfrx_back.sv -----
// Back end: frame parser, check sums, link timer and config registers.
// Depends on cfrx_pkg; one queued beat is retired per cycle while the result queue has space.
`timescale 1ns / 1ps
module cfrx_back import cfrx_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  front_out_type          front_out,
   output logic                   take,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output rsp_item_type           rsp_item
);

   logic [7:0]  hb_cmd_ff;
   logic [15:0] limit_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [5:0]  left_ff, left_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  add_ff, add_in;
   logic        matched_ff, matched_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic        offline_ff, offline_in;

   req_item_type it;
   logic [7:0]   acc_base, sum_next, add_next;
   logic [16:0]  tick_sum;
   logic [5:0]   left_dec;
   logic         do_acc;

   assign csr_ready = 1'b1;
   assign it        = front_out.item;
   assign take      = front_out.avail && !rsp_full;
   assign rsp_push  = take;

   // running sums; a first sync byte restarts them
   assign acc_base = (phase_ff == PH_IDLE) ? 8'd0 : sum_ff;
   assign sum_next = acc_base + it.rx_byte;
   assign add_next = ((phase_ff == PH_IDLE) ? 8'd0 : add_ff) + sum_next;
   assign tick_sum = {1'b0, elapsed_ff} + {9'd0, it.tick_ms};
   assign left_dec = left_ff - 6'd1;

   always_comb begin
      phase_in   = phase_ff;
      left_in    = left_ff;
      sum_in     = sum_ff;
      add_in     = add_ff;
      matched_in = matched_ff;
      cmd_in     = cmd_ff;
      elapsed_in = elapsed_ff;
      offline_in = offline_ff;
      do_acc     = 1'b0;
      rsp_item   = '0;

      if (it.opcode == OP_TICK) begin
         if (elapsed_ff < limit_ff) begin
            elapsed_in = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];
         end else begin
            offline_in = 1'b1;
         end
      end else begin
         priority if (phase_ff == PH_IDLE && it.is_sync_first) begin
            phase_in = PH_SYNC1;
            do_acc   = 1'b1;
         end else if (phase_ff == PH_SYNC1 && it.is_sync_second) begin
            phase_in = PH_SYNC2;
            do_acc   = 1'b1;
         end else if (phase_ff == PH_SYNC2) begin
            phase_in = PH_CMD;
            cmd_in   = it.rx_byte;
            do_acc   = 1'b1;
         end else if (phase_ff == PH_CMD && it.len_ok) begin
            phase_in = PH_PAYLOAD;
            left_in  = it.rx_byte[5:0];
            do_acc   = 1'b1;
         end else if (phase_ff == PH_PAYLOAD && left_ff != 6'd0) begin
            left_in = left_dec;
            do_acc  = 1'b1;
            if (left_dec == 6'd0) begin
               phase_in = PH_SUMCHK;
            end
         end else if (phase_ff == PH_SUMCHK) begin
            phase_in   = PH_ADDCHK;
            matched_in = (it.rx_byte == sum_ff);
         end else if (phase_ff == PH_ADDCHK) begin
            phase_in               = PH_IDLE;
            rsp_item.frame_command = cmd_ff;
            if (matched_ff && it.rx_byte == add_ff) begin
               rsp_item.frame_valid = 1'b1;
               if (cmd_ff == hb_cmd_ff) begin
                  rsp_item.heartbeat_seen = 1'b1;
                  elapsed_in              = 16'd0;
                  offline_in              = 1'b0;
               end
            end
         end else begin
            // bad sync, oversize length, empty payload, unused phase
            phase_in = PH_IDLE;
         end
      end

      if (do_acc) begin
         sum_in = sum_next;
         add_in = add_next;
      end
      rsp_item.link_offline = offline_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         left_ff    <= 6'd0;
         sum_ff     <= 8'd0;
         add_ff     <= 8'd0;
         matched_ff <= 1'b0;
         cmd_ff     <= 8'd0;
         elapsed_ff <= 16'd0;
         offline_ff <= 1'b0;
      end else if (take) begin
         phase_ff   <= phase_in;
         left_ff    <= left_in;
         sum_ff     <= sum_in;
         add_ff     <= add_in;
         matched_ff <= matched_in;
         cmd_ff     <= cmd_in;
         elapsed_ff <= elapsed_in;
         offline_ff <= offline_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hb_cmd_ff <= HEARTBEAT_CMD_RESET;
         limit_ff  <= OFFLINE_LIMIT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_HEARTBEAT_CMD) begin
            hb_cmd_ff <= csr_wdata[7:0];
         end else if (csr_index == CSR_OFFLINE_LIMIT) begin
            limit_ff <= csr_wdata;
         end
      end
   end

endmodule

// ----- rtl/core/cfrx_rsp_q.sv -----
// Two-entry result queue between the back end and the response ports.
// Depends on cfrx_pkg.
`timescale 1ns / 1ps
module cfrx_rsp_q import cfrx_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         enq,
   input  rsp_item_type enq_item,
   output logic         q_full,
   input  logic         pop,
   output logic         empty,
   output rsp_item_type head
);

   rsp_item_type entry_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff, count_in;
   logic         enq_ok, pop_ok;

   assign q_full = (count_ff == 2'd2);
   assign empty  = (count_ff == 2'd0);
   assign enq_ok = enq && !q_full;
   assign pop_ok = pop && !empty;
   assign head   = entry_ff[rd_ptr_ff];
   assign count_in = count_ff + {1'b0, enq_ok} - {1'b0, pop_ok};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ enq_ok;
         rd_ptr_ff <= rd_ptr_ff ^ pop_ok;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq_ok) begin
         entry_ff[wr_ptr_ff] <= enq_item;
      end
   end

endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for checked_frame_receiver_with_link_timeout_unit.
// Needs cfrx_pkg and the unit; runs a directed frame table, then random frames and
// ticks under several link settings and idle mixes, each beat checked on the fly.
`timescale 1ns / 1ps
module testbench;
   import cfrx_pkg::*;

   localparam int RX_HOLD_CYCLES = 200;

   typedef struct packed {
      logic         opcode;
      logic [7:0]   rx_byte;
      logic [7:0]   tick_ms;
      logic         known;   // want holds a hand-written status
      rsp_item_type want;
   } frame_beat_type;

   localparam rsp_item_type NO_FRAME = '0;

   // Directed beats, link settings at their reset values.
   localparam frame_beat_type DIRECTED_ROWS [28] = '{
      '{OP_TICK, 8'h00, 8'h00, 1'b1, NO_FRAME},
      '{OP_TICK, 8'h5A, 8'hFF, 1'b1, NO_FRAME},
      // wrong sync in either sync phase
      '{OP_BYTE, 8'hAA, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h55, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h00, 8'h00, 1'b1, NO_FRAME},
      // heartbeat frame, one payload byte
      '{OP_BYTE, 8'hAA, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'hFF, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'hF5, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h01, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h11, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'hB0, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h40, 8'h00, 1'b0, NO_FRAME},
      // zero length: next byte dropped
      '{OP_BYTE, 8'hAA, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'hFF, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h01, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h00, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h77, 8'h00, 1'b1, NO_FRAME},
      // length at the limit
      '{OP_BYTE, 8'hAA, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'hFF, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h02, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h32, 8'h00, 1'b1, NO_FRAME},
      // bad sum check: command reported, frame not valid
      '{OP_BYTE, 8'hAA, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'hFF, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h03, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h01, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'hFE, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h00, 8'h00, 1'b1, NO_FRAME},
      '{OP_BYTE, 8'h00, 8'h00, 1'b1, '{1'b0, 8'h03, 1'b0, 1'b0}}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   logic                   req_opcode = OP_BYTE;
   logic [7:0]             req_rx_byte = 8'h00;
   logic [7:0]             req_tick_ms = 8'h00;
   logic                   empty;
   logic                   pop = 1'b0;
   logic                   rsp_frame_valid;
   logic [7:0]             rsp_frame_command;
   logic                   rsp_heartbeat_seen;
   logic                   rsp_link_offline;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_HEARTBEAT_CMD;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // link settings and parser state as the unit should hold them
   logic [7:0]  cfg_heartbeat_cmd;
   logic [15:0] cfg_offline_limit;
   logic [2:0]  px_phase;
   logic [5:0]  px_left;
   logic [7:0]  px_sum;
   logic [7:0]  px_add;
   logic        px_sum_ok;
   logic [7:0]  px_cmd;
   logic [15:0] link_elapsed_ms;
   logic        link_down;

   frame_beat_type tx_backlog[$];
   rsp_item_type   frame_status_q[$];
   int             items_queued = 0;
   int             fail_count = 0;
   int             req_gap_pct = 0;
   int             rsp_stall_pct = 0;
   int             stall_requests = 0;
   int             stalls_served = 0;
   int             hold_left = 0;

   checked_frame_receiver_with_link_timeout_unit dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_opcode         (req_opcode),
      .req_rx_byte        (req_rx_byte),
      .req_tick_ms        (req_tick_ms),
      .empty              (empty),
      .pop                (pop),
      .rsp_frame_valid    (rsp_frame_valid),
      .rsp_frame_command  (rsp_frame_command),
      .rsp_heartbeat_seen (rsp_heartbeat_seen),
      .rsp_link_offline   (rsp_link_offline),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void fold_check_byte(input logic [7:0] b);
      px_sum = px_sum + b;
      px_add = px_add + px_sum;
   endfunction

   function automatic rsp_item_type predict_frame_rx(input logic op, input logic [7:0] b,
                                                     input logic [7:0] t);
      rsp_item_type r;
      logic [16:0]  grown;
      r = '0;
      if (op == OP_TICK) begin
         if (link_elapsed_ms < cfg_offline_limit) begin
            grown = {1'b0, link_elapsed_ms} + t;
            link_elapsed_ms = grown[16] ? 16'hFFFF : grown[15:0];
         end else begin
            link_down = 1'b1;
         end
      end else if (px_phase == PH_IDLE && b == SYNC_FIRST) begin
         px_phase = PH_SYNC1;
         px_sum = '0;
         px_add = '0;
         fold_check_byte(b);
      end else if (px_phase == PH_SYNC1 && b == SYNC_SECOND) begin
         px_phase = PH_SYNC2;
         fold_check_byte(b);
      end else if (px_phase == PH_SYNC2) begin
         px_phase = PH_CMD;
         px_cmd = b;
         fold_check_byte(b);
      end else if (px_phase == PH_CMD && b < PAYLOAD_LIMIT) begin
         px_phase = PH_PAYLOAD;
         px_left = b[5:0];
         fold_check_byte(b);
      end else if (px_phase == PH_PAYLOAD && px_left != 0) begin
         px_left = px_left - 6'd1;
         fold_check_byte(b);
         if (px_left == 0) px_phase = PH_SUMCHK;
      end else if (px_phase == PH_SUMCHK) begin
         px_phase = PH_ADDCHK;
         px_sum_ok = (b == px_sum);
      end else if (px_phase == PH_ADDCHK) begin
         px_phase = PH_IDLE;
         r.frame_command = px_cmd;
         if (px_sum_ok && b == px_add) begin
            r.frame_valid = 1'b1;
            if (px_cmd == cfg_heartbeat_cmd) begin
               r.heartbeat_seen = 1'b1;
               link_elapsed_ms = '0;
               link_down = 1'b0;
            end
         end
      end else begin
         // zero-length drop and any stray byte land here
         px_phase = PH_IDLE;
      end
      r.link_offline = link_down;
      return r;
   endfunction

   // ---------------- request side ----------------
   task automatic accept_req_beat();
      frame_beat_type beat;
      rsp_item_type   got;
      beat = tx_backlog.pop_front();
      got = predict_frame_rx(beat.opcode, beat.rx_byte, beat.tick_ms);
      frame_status_q.push_back(beat.known ? beat.want : got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) accept_req_beat();
         if (push && full) begin
            // hold the beat until it goes in
         end else if (tx_backlog.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
            push <= 1'b1;
            req_opcode <= tx_backlog[0].opcode;
            req_rx_byte <= tx_backlog[0].rx_byte;
            req_tick_ms <= tx_backlog[0].tick_ms;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // ---------------- result side ----------------
   task automatic check_status_beat();
      rsp_item_type want;
      if (frame_status_q.size() == 0) begin
         $error("result beat with nothing outstanding");
         fail_count++;
      end else begin
         want = frame_status_q.pop_front();
         if (rsp_frame_valid !== want.frame_valid) begin
            $error("frame_valid: expected %0d, got %0d", want.frame_valid, rsp_frame_valid);
            fail_count++;
         end
         if (rsp_frame_command !== want.frame_command) begin
            $error("frame_command: expected %02h, got %02h", want.frame_command,
                   rsp_frame_command);
            fail_count++;
         end
         if (rsp_heartbeat_seen !== want.heartbeat_seen) begin
            $error("heartbeat_seen: expected %0d, got %0d", want.heartbeat_seen,
                   rsp_heartbeat_seen);
            fail_count++;
         end
         if (rsp_link_offline !== want.link_offline) begin
            $error("link_offline: expected %0d, got %0d", want.link_offline, rsp_link_offline);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) check_status_beat();
         if (stalls_served != stall_requests) begin
            stalls_served <= stall_requests;
            hold_left <= RX_HOLD_CYCLES;
            pop <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ---------------- stimulus ----------------
   function automatic logic [7:0] rand_tick();
      if ($urandom_range(6) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
      return 8'($urandom_range(255));
   endfunction

   task automatic queue_item(input logic op, input logic [7:0] b, input logic [7:0] t);
      frame_beat_type beat;
      beat = '0;
      beat.opcode = op;
      beat.rx_byte = b;
      beat.tick_ms = t;
      tx_backlog.push_back(beat);
      items_queued++;
   endtask

   task automatic queue_byte(input logic [7:0] b);
      queue_item(OP_BYTE, b, 8'($urandom_range(255)));
   endtask

   task automatic queue_tick(input logic [7:0] t);
      queue_item(OP_TICK, 8'($urandom_range(255)), t);
   endtask

   // damage: 0 clean, 1 bad sum check, 2 bad add check
   task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] len, input int damage);
      logic [7:0] bytes[$];
      logic [7:0] s;
      logic [7:0] a;
      bytes.push_back(SYNC_FIRST);
      bytes.push_back(SYNC_SECOND);
      bytes.push_back(cmd);
      bytes.push_back(len);
      for (int i = 0; i < len; i++) bytes.push_back(8'($urandom_range(255)));
      s = '0;
      a = '0;
      foreach (bytes[i]) begin
         s = s + bytes[i];
         a = a + s;
      end
      if (damage == 1) s = s ^ 8'($urandom_range(1, 255));
      if (damage == 2) a = a ^ 8'($urandom_range(1, 255));
      bytes.push_back(s);
      bytes.push_back(a);
      foreach (bytes[i]) begin
         // ticks mid-frame must not disturb the parser
         if ($urandom_range(9) == 0) queue_tick(rand_tick());
         queue_byte(bytes[i]);
      end
   endtask

   task automatic queue_random_traffic(input int n);
      int         start;
      int         pick;
      int         damage;
      int         cut;
      logic [7:0] cmd;
      logic [7:0] len;
      start = items_queued;
      while (items_queued - start < n) begin
         pick = $urandom_range(99);
         cmd = ($urandom_range(2) == 0) ? cfg_heartbeat_cmd : 8'($urandom_range(255));
         if (pick < 55) begin
            len = ($urandom_range(9) < 8) ? 8'($urandom_range(1, 6))
                                          : 8'($urandom_range(7, PAYLOAD_LIMIT - 1));
            damage = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 2);
            queue_frame(cmd, len, damage);
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 4)) queue_tick(rand_tick());
         end else if (pick < 83) begin
            repeat ($urandom_range(1, 3))
               queue_byte(($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom_range(255)));
         end else if (pick < 88) begin
            queue_byte(SYNC_FIRST);
            queue_byte(8'($urandom_range(254)));
         end else if (pick < 93) begin
            queue_byte(SYNC_FIRST);
            queue_byte(SYNC_SECOND);
            queue_byte(cmd);
            queue_byte(8'h00);
            queue_byte(8'($urandom_range(255)));
         end else if (pick < 97) begin
            queue_byte(SYNC_FIRST);
            queue_byte(SYNC_SECOND);
            queue_byte(cmd);
            queue_byte(8'($urandom_range(PAYLOAD_LIMIT, 255)));
         end else begin
            // truncated frame; what follows gets swallowed as payload
            len = 8'($urandom_range(2, 6));
            cut = $urandom_range(0, len - 1);
            queue_byte(SYNC_FIRST);
            queue_byte(SYNC_SECOND);
            queue_byte(cmd);
            queue_byte(len);
            repeat (cut) queue_byte(8'($urandom_range(255)));
         end
      end
   endtask

   task automatic drain_all();
      while (tx_backlog.size() != 0 || frame_status_q.size() != 0) @(posedge clock);
   endtask

   // both registers back to back, valid held high across the two beats
   task automatic set_link_config(input logic [7:0] hb_cmd, input logic [15:0] limit_ms);
      csr_index <= CSR_HEARTBEAT_CMD;
      csr_wdata <= {8'h00, hb_cmd};
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_heartbeat_cmd = hb_cmd;
      csr_index <= CSR_OFFLINE_LIMIT;
      csr_wdata <= limit_ms;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_offline_limit = limit_ms;
      csr_valid <= 1'b0;
   endtask

   initial begin
      cfg_heartbeat_cmd = HEARTBEAT_CMD_RESET;
      cfg_offline_limit = OFFLINE_LIMIT_RESET;
      px_phase = PH_IDLE;
      px_left = '0;
      px_sum = '0;
      px_add = '0;
      px_sum_ok = 1'b0;
      px_cmd = '0;
      link_elapsed_ms = '0;
      link_down = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) tx_backlog.push_back(DIRECTED_ROWS[i]);
      drain_all();

      // low extremes; every tick goes offline. Receiver holds off mid-run to fill the unit,
      // then the sender waits for the unit to empty.
      set_link_config(8'h00, 16'd0);
      queue_random_traffic(110);
      while (tx_backlog.size() > 80) @(posedge clock);
      stall_requests <= stall_requests + 1;
      drain_all();
      queue_random_traffic(110);
      drain_all();

      // high extremes; long tick run drives the timer into saturation
      set_link_config(8'hFF, 16'hFFFF);
      req_gap_pct <= 77;
      repeat (360) queue_tick(8'($urandom_range(128, 255)));
      queue_random_traffic(150);
      drain_all();

      set_link_config(8'($urandom_range(255)), 16'($urandom_range(300, 1500)));
      req_gap_pct <= 0;
      rsp_stall_pct <= 77;
      queue_random_traffic(220);
      drain_all();

      set_link_config(HEARTBEAT_CMD_RESET, OFFLINE_LIMIT_RESET);
      req_gap_pct <= 27;
      rsp_stall_pct <= 27;
      queue_random_traffic(220);
      drain_all();

      repeat (20) @(posedge clock);
      if (fail_count == 0 && frame_status_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
